@@ rtl/assert_macros.svh @@
// Assertion macros used by the power vote controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define PVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pvc_pkg.sv @@
// Types, constants and helpers for the power vote controller
package pvc_pkg;

    localparam int NUM_VOTERS = 12;
    localparam int WORD_SLOTS = 12;
    localparam int SLOT_BITS  = 4;
    localparam int WORD_BITS  = WORD_SLOTS * SLOT_BITS;

    localparam logic [WORD_BITS-1:0] ALL_OFF  = {WORD_SLOTS{4'h5}};
    localparam logic [SLOT_BITS-1:0] SLOT_ON  = 4'hA;
    localparam logic [SLOT_BITS-1:0] SLOT_OFF = 4'h5;

    localparam logic [3:0]  FACTORY_VOTER_RST = 4'd0;
    localparam logic [31:0] OFF_DELAY_RST     = 32'd10;

    // configuration register indexes
    localparam logic REG_FACTORY_VOTER = 1'b0;
    localparam logic REG_OFF_DELAY     = 1'b1;

    typedef enum logic [2:0] {
        MODE_VOTE_ON      = 3'd0,
        MODE_VOTE_OFF     = 3'd1,
        MODE_FACTORY_IN   = 3'd2,
        MODE_FACTORY_OUT  = 3'd3,
        MODE_SUSPEND      = 3'd4,
        MODE_TICK         = 3'd5
    } pvc_mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FACTORY  = 3'd2,
        ST_SWFAIL   = 3'd3,
        ST_VOTES_ON = 3'd4
    } pvc_status_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] vote_bits;
        logic                 factory_flag;
        logic                 timer_present;
        logic [31:0]          off_countdown;
    } pvc_state_t;

    typedef struct packed {
        logic                 factory_active;
        logic [WORD_BITS-1:0] vote_word;
        logic [1:0]           power_off_cmds;
        logic                 power_on_cmd;
        pvc_status_t          status;
    } pvc_result_t;

    // Overwrite one 4-bit slot; ids outside the word leave it untouched
    function automatic logic [WORD_BITS-1:0] set_slot(input logic [WORD_BITS-1:0] word,
                                                      input logic [3:0] id,
                                                      input logic [SLOT_BITS-1:0] unit);
        logic [WORD_BITS-1:0] w;
        w = word;
        for (int i = 0; i < WORD_SLOTS; i++)
        begin
            if ({1'b0, id} == 5'(i))
            begin
                w[i*SLOT_BITS +: SLOT_BITS] = unit;
            end
        end
        return w;
    endfunction

    function automatic logic voter_valid(input logic [3:0] id);
        return ({1'b0, id} < 5'(NUM_VOTERS)) && ({1'b0, id} < 5'(WORD_SLOTS));
    endfunction

endpackage

@@ rtl/pvc_step.sv @@
// Single-pass request logic: next state and result for one request
module pvc_step
    import pvc_pkg::*;
(
    input  logic [2:0]  mode,
    input  logic [3:0]  vote_id,
    input  logic        switch_ok,
    input  logic [3:0]  factory_voter,
    input  logic [31:0] off_delay_ticks,
    input  pvc_state_t  cur,
    output pvc_state_t  nxt,
    output pvc_result_t res
);

    logic                 all_off;
    logic [WORD_BITS-1:0] word_tmp;
    logic [31:0]          cd_dec;
    logic [1:0]           off_cnt;
    pvc_status_t          status;
    logic                 on_cmd;

    assign all_off = (cur.vote_bits == ALL_OFF);
    assign cd_dec  = cur.off_countdown - 32'd1;

    always_comb
    begin
        nxt      = cur;
        status   = ST_OK;
        on_cmd   = 1'b0;
        off_cnt  = 2'd0;
        word_tmp = cur.vote_bits;
        unique case (mode)
            MODE_VOTE_ON:
            begin
                if (!voter_valid(vote_id))
                begin
                    status = ST_INVALID;
                end
                else if (cur.factory_flag && (vote_id != factory_voter))
                begin
                    status = ST_FACTORY;
                end
                else
                begin
                    if (all_off)
                    begin
                        // first on-vote kills the deferred off and powers up
                        nxt.timer_present = 1'b0;
                        nxt.off_countdown = 32'd0;
                        on_cmd            = 1'b1;
                    end
                    if (all_off && !switch_ok)
                    begin
                        status = ST_SWFAIL;
                    end
                    else
                    begin
                        nxt.vote_bits = set_slot(cur.vote_bits, vote_id, SLOT_ON);
                    end
                end
            end
            MODE_VOTE_OFF:
            begin
                if (!voter_valid(vote_id))
                begin
                    status = ST_INVALID;
                end
                else if (!all_off)
                begin
                    word_tmp      = set_slot(cur.vote_bits, vote_id, SLOT_OFF);
                    nxt.vote_bits = word_tmp;
                    if (word_tmp == ALL_OFF)
                    begin
                        nxt.timer_present = 1'b1;
                        nxt.off_countdown = (off_delay_ticks == 32'd0) ? 32'd1
                                                                       : off_delay_ticks;
                    end
                end
            end
            MODE_FACTORY_IN:
            begin
                word_tmp      = set_slot(cur.vote_bits, factory_voter, SLOT_OFF);
                nxt.vote_bits = word_tmp;
                if (word_tmp != ALL_OFF)
                begin
                    status = ST_FACTORY;
                end
                else
                begin
                    off_cnt = 2'd1;
                    if (!switch_ok)
                        status = ST_SWFAIL;
                    else
                        nxt.factory_flag = 1'b1;
                end
            end
            MODE_FACTORY_OUT:
            begin
                off_cnt = 2'd1;
                if (!switch_ok)
                    status = ST_SWFAIL;
                else
                    nxt.factory_flag = 1'b0;
            end
            MODE_SUSPEND:
            begin
                if (!all_off)
                begin
                    nxt.vote_bits = ALL_OFF;
                    off_cnt       = off_cnt + 2'd1;
                end
                if (cur.timer_present)
                begin
                    nxt.timer_present = 1'b0;
                    nxt.off_countdown = 32'd0;
                    off_cnt           = off_cnt + 2'd1;
                end
            end
            MODE_TICK:
            begin
                if (cur.timer_present && (cur.off_countdown != 32'd0))
                begin
                    nxt.off_countdown = cd_dec;
                    if (cd_dec == 32'd0)
                    begin
                        if (!all_off)
                        begin
                            status = ST_VOTES_ON;
                        end
                        else
                        begin
                            off_cnt = 2'd1;
                            if (!switch_ok)
                                status = ST_SWFAIL;
                        end
                    end
                end
            end
            default:
            begin
                // unused modes: no change
            end
        endcase
    end

    assign res.status         = status;
    assign res.power_on_cmd   = on_cmd;
    assign res.power_off_cmds = off_cnt;
    assign res.vote_word      = nxt.vote_bits;
    assign res.factory_active = nxt.factory_flag;

endmodule

@@ rtl/power_vote_controller.sv @@
// Power vote controller top level: request register, step logic, result register
// A request passes through the request register, then the result register.
// One request per cycle unless m_tready stalls; state update: a single pvc_step pass.
// The request register advances whenever the result register is empty or being taken.
// Reset (rst_n, async, active low): votes all off, factory mode off, no timer,
// factory_voter 0, off_delay_ticks 10, both stages empty.
`include "assert_macros.svh"
module power_vote_controller
    import pvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // mode[2:0], vote_id[6:3], switch_ok[7]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[2:0], power_on_cmd[3], power_off_cmds[5:4],
                                   // vote_word[53:6], factory_active[54], pad[55]
);

    // configuration registers
    logic [3:0]  factory_voter_reg;
    logic [31:0] off_delay_reg;

    // request register
    logic        in_valid_reg;
    logic [2:0]  mode_reg;
    logic [3:0]  vote_id_reg;
    logic        switch_ok_reg;

    // controller state and result register
    pvc_state_t  state_reg;
    pvc_state_t  state_next;
    pvc_result_t res_next;
    pvc_result_t res_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;

    // result slot is free when empty or when its transfer completes now
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factory_voter_reg <= FACTORY_VOTER_RST;
            off_delay_reg     <= OFF_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FACTORY_VOTER: factory_voter_reg <= wr_data[3:0];
                REG_OFF_DELAY:     off_delay_reg     <= wr_data;
                default:           ;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg      <= s_tdata[2:0];
            vote_id_reg   <= s_tdata[6:3];
            switch_ok_reg <= s_tdata[7];
        end
    end

    pvc_step u_step
    (
        .mode            (mode_reg),
        .vote_id         (vote_id_reg),
        .switch_ok       (switch_ok_reg),
        .factory_voter   (factory_voter_reg),
        .off_delay_ticks (off_delay_reg),
        .cur             (state_reg),
        .nxt             (state_next),
        .res             (res_next)
    );

    // state commits only when the request moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.vote_bits     <= ALL_OFF;
            state_reg.factory_flag  <= 1'b0;
            state_reg.timer_present <= 1'b0;
            state_reg.off_countdown <= 32'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.factory_active, res_reg.vote_word,
                       res_reg.power_off_cmds, res_reg.power_on_cmd, res_reg.status};

    // checks
    `PVC_ASSERT_SAME(a_idle_timer, !state_reg.timer_present, state_reg.off_countdown == 32'd0, "countdown running without a timer")
    `PVC_ASSERT_NEXT(a_state_hold, !advance, $stable(state_reg), "state changed with no request")
    `PVC_ASSERT_SAME(a_factory_rise, $rose(state_reg.factory_flag), $past(advance && (mode_reg == MODE_FACTORY_IN)), "factory mode set without an entry request")
    `PVC_ASSERT_SAME(a_on_status, out_valid_reg && res_reg.power_on_cmd, (res_reg.status == ST_OK) || (res_reg.status == ST_SWFAIL), "power-on with unexpected status")

endmodule

@@ bench/power_vote_controller_tb.sv @@
// Self-checking testbench for the power vote controller: directed table, then random phases
`timescale 1ns / 100ps

module power_vote_controller_tb;
    import pvc_pkg::*;

    // modes the block must treat as no-ops
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // generous watchdog limit on the whole run
    localparam int CYCLE_LIMIT = 200000;
    // receiver hold-off, started once this many results have been taken
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic        wr_index = 1'b0;
    logic [31:0] wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // mode[2:0], vote_id[6:3], switch_ok[7]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // status[2:0], power_on_cmd[3], power_off_cmds[5:4],
                                   // vote_word[53:6], factory_active[54], pad[55]

    // one row of the directed table; want is used only where known is set
    typedef struct {
        logic [2:0]  mode;
        logic [3:0]  vid;
        logic        ok;
        bit          known;
        pvc_result_t want;
    } stim_row_t;

    stim_row_t   directed_rows[$];
    pvc_result_t expected_results[$];

    // predictor copy of the block's registers and state
    logic [3:0]           cfg_factory_voter = FACTORY_VOTER_RST;
    logic [31:0]          cfg_off_delay     = OFF_DELAY_RST;
    logic [WORD_BITS-1:0] votes             = ALL_OFF;
    logic                 in_factory        = 1'b0;
    logic                 timer_alive       = 1'b0;
    logic [31:0]          countdown         = '0;

    int tx_idle_pct  = 33;
    int rx_idle_pct  = 33;
    int mismatches   = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int cycle_count  = 0;

    power_vote_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Slot write; ids past the end of the word leave it alone
    function automatic logic [WORD_BITS-1:0] with_slot(input logic [WORD_BITS-1:0] word,
                                                       input logic [3:0] vid,
                                                       input logic [SLOT_BITS-1:0] unit);
        logic [WORD_BITS-1:0] w;
        w = word;
        if (vid < WORD_SLOTS)
        begin
            w[vid*SLOT_BITS +: SLOT_BITS] = unit;
        end
        return w;
    endfunction

    // Advance the predicted state by one request and return the result it yields
    function automatic pvc_result_t predict_vote_step(input logic [2:0] mode,
                                                      input logic [3:0] vid,
                                                      input logic ok);
        pvc_result_t r;
        logic        id_ok;
        r.status         = ST_OK;
        r.power_on_cmd   = 1'b0;
        r.power_off_cmds = 2'd0;
        id_ok = (vid < NUM_VOTERS) && (vid < WORD_SLOTS);
        case (mode)
            MODE_VOTE_ON:
            begin
                if (!id_ok)
                    r.status = ST_INVALID;
                else if (in_factory && vid != cfg_factory_voter)
                    r.status = ST_FACTORY;
                else if (votes == ALL_OFF)
                begin
                    // first on-vote: any deferred power-off dies even if the switch refuses
                    timer_alive    = 1'b0;
                    countdown      = '0;
                    r.power_on_cmd = 1'b1;
                    if (ok)
                        votes = with_slot(votes, vid, SLOT_ON);
                    else
                        r.status = ST_SWFAIL;
                end
                else
                    votes = with_slot(votes, vid, SLOT_ON);
            end
            MODE_VOTE_OFF:
            begin
                if (!id_ok)
                    r.status = ST_INVALID;
                else if (votes != ALL_OFF)
                begin
                    votes = with_slot(votes, vid, SLOT_OFF);
                    if (votes == ALL_OFF)
                    begin
                        timer_alive = 1'b1;
                        countdown   = (cfg_off_delay != 0) ? cfg_off_delay : 32'd1;
                    end
                end
            end
            MODE_FACTORY_IN:
            begin
                votes = with_slot(votes, cfg_factory_voter, SLOT_OFF);
                if (votes != ALL_OFF)
                    r.status = ST_FACTORY;
                else
                begin
                    r.power_off_cmds = 2'd1;
                    if (ok)
                        in_factory = 1'b1;
                    else
                        r.status = ST_SWFAIL;
                end
            end
            MODE_FACTORY_OUT:
            begin
                r.power_off_cmds = 2'd1;
                if (ok)
                    in_factory = 1'b0;
                else
                    r.status = ST_SWFAIL;
            end
            MODE_SUSPEND:
            begin
                // switch_ok is ignored here
                if (votes != ALL_OFF)
                begin
                    votes            = ALL_OFF;
                    r.power_off_cmds = r.power_off_cmds + 2'd1;
                end
                if (timer_alive)
                begin
                    timer_alive      = 1'b0;
                    countdown        = '0;
                    r.power_off_cmds = r.power_off_cmds + 2'd1;
                end
            end
            MODE_TICK:
            begin
                if (timer_alive && countdown != 0)
                begin
                    countdown = countdown - 32'd1;
                    // expiry leaves the timer present but idle
                    if (countdown == 0)
                    begin
                        if (votes != ALL_OFF)
                            r.status = ST_VOTES_ON;
                        else
                        begin
                            r.power_off_cmds = 2'd1;
                            if (!ok)
                                r.status = ST_SWFAIL;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.vote_word      = votes;
        r.factory_active = in_factory;
        return r;
    endfunction

    function automatic void row(input logic [2:0] mode, input logic [3:0] vid, input logic ok);
        stim_row_t t;
        t.mode  = mode;
        t.vid   = vid;
        t.ok    = ok;
        t.known = 1'b0;
        t.want  = '0;
        directed_rows.push_back(t);
    endfunction

    function automatic void row_known(input logic [2:0] mode, input logic [3:0] vid,
                                      input logic ok, input pvc_status_t status,
                                      input logic on_cmd, input logic [1:0] off_cmds,
                                      input logic [WORD_BITS-1:0] word, input logic fact);
        stim_row_t t;
        t.mode                = mode;
        t.vid                 = vid;
        t.ok                  = ok;
        t.known               = 1'b1;
        t.want.status         = status;
        t.want.power_on_cmd   = on_cmd;
        t.want.power_off_cmds = off_cmds;
        t.want.vote_word      = word;
        t.want.factory_active = fact;
        directed_rows.push_back(t);
    endfunction

    // Offer one request, hold it until the transfer, then queue its expected result.
    // tvalid is only lowered when an idle cycle is actually inserted.
    task automatic issue_request(input logic [2:0] mode, input logic [3:0] vid,
                                 input logic ok, input bit known, input pvc_result_t want);
        pvc_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ok, vid, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_vote_step(mode, vid, ok);
        expected_results.push_back(known ? want : predicted);
    endtask

    // Registers change only once the block has drained every result
    task automatic load_settings(input logic [3:0] fv, input logic [31:0] delay);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_FACTORY_VOTER;
        wr_data  <= {28'd0, fv};
        @(posedge clk);
        wr_index <= REG_OFF_DELAY;
        wr_data  <= delay;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_factory_voter = fv;
        cfg_off_delay     = delay;
    endtask

    // Mostly legal vote traffic with ticks to reach expiry; a slice of raw noise
    task automatic random_burst(input int count);
        logic [2:0] mode;
        logic [3:0] vid;
        logic       ok;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            ok   = ($urandom_range(99) < 85);
            vid  = 4'($urandom_range(11));
            if ($urandom_range(3) == 0)
                vid = cfg_factory_voter;
            if (pick < 32)
                mode = MODE_VOTE_ON;
            else if (pick < 54)
                mode = MODE_VOTE_OFF;
            else if (pick < 82)
                mode = MODE_TICK;
            else if (pick < 86)
                mode = MODE_FACTORY_IN;
            else if (pick < 90)
                mode = MODE_FACTORY_OUT;
            else if (pick < 93)
                mode = MODE_SUSPEND;
            else
            begin
                mode = 3'($urandom_range(7));
                vid  = 4'($urandom_range(15));
            end
            issue_request(mode, vid, ok, 1'b0, '0);
        end
    endtask

    // Result sink: random back-pressure, plus one long hold-off that lets the
    // pipeline fill and forces s_tready low while requests keep coming
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge clk)
    begin : check_results
        pvc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[3] !== want.power_on_cmd)
                begin
                    $error("power_on_cmd: expected %0d, got %0d", want.power_on_cmd,
                           m_tdata[3]);
                    mismatches++;
                end
                if (m_tdata[5:4] !== want.power_off_cmds)
                begin
                    $error("power_off_cmds: expected %0d, got %0d", want.power_off_cmds,
                           m_tdata[5:4]);
                    mismatches++;
                end
                if (m_tdata[53:6] !== want.vote_word)
                begin
                    $error("vote_word: expected %h, got %h", want.vote_word, m_tdata[53:6]);
                    mismatches++;
                end
                if (m_tdata[54] !== want.factory_active)
                begin
                    $error("factory_active: expected %0d, got %0d", want.factory_active,
                           m_tdata[54]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero delay acts as one tick, so expiry is quick to reach.
        // Rows with typed results are the ones readable straight from reset state.
        load_settings(4'd0, 32'd0);
        row_known(MODE_TICK,     4'd0,  1'b1, ST_OK,      1'b0, 2'd0, ALL_OFF, 1'b0);
        row_known(MODE_VOTE_OFF, 4'd3,  1'b1, ST_OK,      1'b0, 2'd0, ALL_OFF, 1'b0);
        row_known(MODE_VOTE_ON,  4'd12, 1'b1, ST_INVALID, 1'b0, 2'd0, ALL_OFF, 1'b0);
        row_known(MODE_VOTE_ON,  4'd15, 1'b0, ST_INVALID, 1'b0, 2'd0, ALL_OFF, 1'b0);
        row_known(MODE_VOTE_OFF, 4'd15, 1'b1, ST_INVALID, 1'b0, 2'd0, ALL_OFF, 1'b0);
        // power-on refused by the switch: vote not recorded
        row_known(MODE_VOTE_ON,  4'd0,  1'b0, ST_SWFAIL,  1'b1, 2'd0, ALL_OFF, 1'b0);
        // top slot turns on
        row_known(MODE_VOTE_ON,  4'd11, 1'b1, ST_OK,      1'b1, 2'd0,
                  48'hA555_5555_5555, 1'b0);
        row(MODE_VOTE_ON,     4'd0,  1'b0);   // second voter, no new power-on
        row(MODE_FACTORY_IN,  4'd9,  1'b1);   // votes still on: conflict
        row(MODE_SPARE_A,     4'd15, 1'b1);
        row(MODE_SPARE_B,     4'd8,  1'b0);
        row(MODE_VOTE_OFF,    4'd11, 1'b1);   // all off, countdown starts
        row(MODE_TICK,        4'd0,  1'b0);   // expiry, switch refuses power-off
        row(MODE_TICK,        4'd0,  1'b1);   // timer expired: idle
        row(MODE_SUSPEND,     4'd0,  1'b0);   // off for the leftover timer
        row(MODE_FACTORY_IN,  4'd0,  1'b0);   // switch failure, flag unchanged
        row(MODE_FACTORY_IN,  4'd0,  1'b1);
        row(MODE_VOTE_ON,     4'd5,  1'b1);   // blocked by factory mode
        row(MODE_VOTE_ON,     4'd0,  1'b1);   // factory voter allowed
        row(MODE_SUSPEND,     4'd0,  1'b1);   // votes on: one power-off
        row(MODE_FACTORY_OUT, 4'd0,  1'b0);
        row(MODE_FACTORY_OUT, 4'd0,  1'b1);
        row(MODE_VOTE_ON,     4'd7,  1'b1);
        row(MODE_VOTE_OFF,    4'd7,  1'b1);
        row(MODE_VOTE_ON,     4'd4,  1'b1);   // kills the running countdown
        row(MODE_TICK,        4'd4,  1'b1);
        foreach (directed_rows[k])
            issue_request(directed_rows[k].mode, directed_rows[k].vid, directed_rows[k].ok,
                          directed_rows[k].known, directed_rows[k].want);

        // Random phases across register settings, extremes included
        load_settings(4'd11, 32'd3);
        random_burst(120);
        load_settings(4'd15, 32'd1);          // factory voter outside the word
        random_burst(120);
        tx_idle_pct = 0;                      // back-to-back stretch on both sides
        rx_idle_pct = 0;
        load_settings(4'd0, 32'hFFFF_FFFF);   // countdown never runs out
        random_burst(120);
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        load_settings(4'd12, 32'd2);
        random_burst(120);
        load_settings(4'd5, 32'd6);
        random_burst(120);

        // Drain, then allow the pipeline latency to settle
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
